// ===== hdl/pcm_pkg.sv =====
// pcm_pkg: shared types and constants for the pwm capture measurement block
// no dependencies; imported by pcm_engine and pwm_capture_measure

package pcm_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 27;

    localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 1'd1;

    localparam logic [26:0] TICK_RATE_RST  = 27'd2000000;
    localparam logic [7:0]  FULL_SCALE_RST = 8'd5;

    // event kinds
    localparam logic CMD_OVERFLOW = 1'b0;
    localparam logic CMD_CAPTURE  = 1'b1;

    // measurement phases
    localparam logic [1:0] PH_FIRST = 2'd0;
    localparam logic [1:0] PH_FALL  = 2'd1;
    localparam logic [1:0] PH_NEXT  = 2'd2;

    // iteration counts of the shared step unit
    localparam int DUTY_STEPS = 7;
    localparam int DIV_STEPS  = 17;
    localparam int SQRT_STEPS = 17;

    localparam logic [6:0] DUTY_SCALE = 7'd100;

    // engine sequencer
    typedef enum logic [2:0] {
        ES_IDLE,
        ES_PREP,
        ES_DUTY,
        ES_FREQ,
        ES_FRAC,
        ES_SQRT,
        ES_SCALE
    } t_eng_state;

    // measurement operands handed to the engine
    typedef struct packed {
        logic [31:0] high;
        logic [31:0] period;
    } t_eng_req;

    // derived values returned by the engine
    typedef struct packed {
        logic [6:0]  duty;
        logic [15:0] freq;
        logic [7:0]  veff;
    } t_eng_res;

endpackage

// ===== hdl/pcm_in_if.sv =====
// pcm_in_if: timer event channel (overflow or edge capture)
// standalone interface, no dependencies

interface pcm_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] capture_count;

    modport source (output valid, output cmd, output capture_count, input ready);
    modport sink   (input valid, input cmd, input capture_count, output ready);
endinterface

// ===== hdl/pcm_out_if.sv =====
// pcm_out_if: measurement result channel
// standalone interface, no dependencies

interface pcm_out_if;
    logic        valid;
    logic        ready;
    logic        arm_falling;
    logic        done_res;
    logic [31:0] high_ticks;
    logic [31:0] period_ticks;
    logic [6:0]  duty_percent;
    logic [15:0] frequency_hz;
    logic [7:0]  veff_volts;
    logic        error;

    modport source (
        output valid, output arm_falling, output done_res, output high_ticks,
        output period_ticks, output duty_percent, output frequency_hz,
        output veff_volts, output error, input ready
    );
    modport sink (
        input valid, input arm_falling, input done_res, input high_ticks,
        input period_ticks, input duty_percent, input frequency_hz,
        input veff_volts, input error, output ready
    );
endinterface

// ===== hdl/pcm_engine.sv =====
// pcm_engine: sequenced compare-subtract unit for duty, frequency and sqrt
// depends on pcm_pkg

module pcm_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  pcm_pkg::t_eng_req i_req,
    input  logic [26:0]       i_tick_rate,
    input  logic [7:0]        i_full_scale,
    output logic              o_busy,
    output pcm_pkg::t_eng_res o_res
);
    import pcm_pkg::*;

    t_eng_state r_state, n_state;
    logic [4:0]  r_cnt;
    logic [31:0] r_period;
    logic [31:0] r_h;
    logic [47:0] r_rem;
    logic [47:0] r_dsr;
    logic [16:0] r_quo;
    logic [33:0] r_root;
    logic [6:0]  r_duty;
    logic [15:0] r_freq;
    logic [7:0]  r_veff;

    logic        s_last;
    logic        s_sqrt;
    logic [47:0] s_b;
    logic [48:0] s_diff;
    logic        s_ge;
    logic [16:0] s_quo;
    logic [33:0] s_root;
    logic [24:0] s_prod;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ES_IDLE:  if (i_start) n_state = ES_PREP;
            ES_PREP:  n_state = ES_DUTY;
            ES_DUTY:  if (s_last) n_state = ES_FREQ;
            ES_FREQ:  if (s_last) n_state = ES_FRAC;
            ES_FRAC:  if (s_last) n_state = ES_SQRT;
            ES_SQRT:  if (s_last) n_state = ES_SCALE;
            ES_SCALE: n_state = ES_IDLE;
            default:  n_state = ES_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_last = 1'b0;
        s_sqrt = 1'b0;
        o_busy = 1'b1;
        unique case (r_state) inside
            ES_IDLE:          o_busy = 1'b0;
            ES_DUTY:          s_last = (r_cnt == 5'(DUTY_STEPS - 1));
            ES_FREQ, ES_FRAC: s_last = (r_cnt == 5'(DIV_STEPS - 1));
            ES_SQRT: begin
                s_sqrt = 1'b1;
                s_last = (r_cnt == 5'(SQRT_STEPS - 1));
            end
            ES_PREP, ES_SCALE: ;
            default: o_busy = 1'b1;
        endcase
    end

    // shared compare-subtract unit
    always_comb begin
        s_b    = s_sqrt ? (r_dsr + {14'd0, r_root}) : r_dsr;
        s_diff = {1'b0, r_rem} - {1'b0, s_b};
        s_ge   = ~s_diff[48];
        s_quo  = {r_quo[15:0], s_ge};
        s_root = (r_root >> 1) + (s_ge ? r_dsr[33:0] : 34'd0);
        s_prod = {17'd0, i_full_scale} * {8'd0, r_root[16:0]};
    end

    // sequencer state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ES_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (n_state != r_state) ? 5'd0 : r_cnt + 5'd1;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ES_IDLE: begin
                if (i_start) begin
                    r_period <= i_req.period;
                    r_h      <= (i_req.high > i_req.period) ? i_req.period : i_req.high;
                end
            end
            ES_PREP: begin
                r_rem <= {16'd0, r_h} * {41'd0, DUTY_SCALE};
                r_dsr <= {10'd0, r_period, 6'd0};
                r_quo <= '0;
            end
            ES_DUTY, ES_FREQ, ES_FRAC: begin
                if (s_last) begin
                    r_quo <= '0;
                    r_dsr <= {r_period, 16'd0};
                    if (r_state == ES_DUTY) begin
                        r_duty <= s_quo[6:0];
                        r_rem  <= {21'd0, i_tick_rate};
                    end else if (r_state == ES_FREQ) begin
                        r_freq <= s_quo[16] ? 16'hFFFF : s_quo[15:0];
                        r_rem  <= {r_h, 16'd0};
                    end else begin
                        // fraction q in Q1.16, root of q << 16 next
                        r_rem  <= {15'd0, s_quo, 16'd0};
                        r_root <= '0;
                        r_dsr  <= 48'h0001_0000_0000;
                    end
                end else begin
                    if (s_ge) r_rem <= s_diff[47:0];
                    r_quo <= s_quo;
                    r_dsr <= r_dsr >> 1;
                end
            end
            ES_SQRT: begin
                if (s_ge) r_rem <= s_diff[47:0];
                r_root <= s_root;
                r_dsr  <= r_dsr >> 2;
            end
            ES_SCALE: r_veff <= s_prod[23:16];
            default: ;
        endcase
    end

    assign o_res.duty = r_duty;
    assign o_res.freq = r_freq;
    assign o_res.veff = r_veff;

endmodule

// ===== hdl/pwm_capture_measure.sv =====
// pwm_capture_measure: pwm input-capture phase tracking and result delivery
// depends on pcm_pkg, pcm_in_if, pcm_out_if and pcm_engine
//
//  port      dir  kind         contents
//  i_in      in   valid/ready  cmd, capture_count
//  o_out     out  valid/ready  arm_falling, done_res, high_ticks, period_ticks,
//                              duty_percent, frequency_hz, veff_volts, error
//  i_cfg_*   in   write only   tick_rate_hz (index 0), full_scale_volts (index 1)
//
// overflow events, first/falling captures and zero-period closing captures give a result
// beat in the cycle after acceptance; a closing capture with nonzero period gets its beat
// once the engine finishes: prep, 7 duty steps, 17 frequency, 17 fraction, 17 sqrt, scale
// the input is not ready while the engine runs or a result beat is stalled
// synchronous active-low reset restores phase, overflow count and register defaults

module pwm_capture_measure #(
    parameter int OVERFLOW_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pcm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pcm_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    pcm_in_if.sink                          i_in,
    pcm_out_if.source                       o_out
);
    import pcm_pkg::*;

    localparam logic [OVERFLOW_BITS-1:0] OVF_MAX = '1;

    // control and configuration state
    logic [1:0]               r_phase;
    logic [15:0]              r_first;
    logic [31:0]              r_hstamp;
    logic [OVERFLOW_BITS-1:0] r_ovf;
    logic                     r_sat;
    logic [26:0]              r_tick;
    logic [7:0]               r_fs;
    logic                     r_busy;
    logic                     r_ovalid, n_ovalid;

    // output payload
    logic        r_arm;
    logic        r_done;
    logic [31:0] r_high;
    logic [31:0] r_period;
    logic [6:0]  r_duty;
    logic [15:0] r_freq;
    logic [7:0]  r_veff;
    logic        r_err;

    logic                     s_in_acc;
    logic                     s_cap;
    logic [31:0]              s_stamp;
    logic [31:0]              s_high;
    logic [31:0]              s_period;
    logic                     s_measure;
    logic                     s_eng_start;
    logic                     s_eng_busy;
    logic                     s_eng_fin;
    logic                     s_arm;
    logic [OVERFLOW_BITS-1:0] s_ovf_inc;
    t_eng_req                 s_req;
    t_eng_res                 s_res;

    assign i_in.ready = !r_busy && (!r_ovalid || o_out.ready);

    // event decode and stamps
    always_comb begin
        s_in_acc    = i_in.valid && i_in.ready;
        s_cap       = (i_in.cmd == CMD_CAPTURE);
        s_stamp     = {16'(r_ovf), i_in.capture_count};
        s_high      = r_hstamp - {16'd0, r_first};
        s_period    = s_stamp - {16'd0, r_first};
        s_measure   = s_in_acc && s_cap && (r_phase == PH_NEXT);
        s_eng_start = s_measure && (s_period != 32'd0);
        s_eng_fin   = r_busy && !s_eng_busy;
        s_ovf_inc   = r_ovf + OVERFLOW_BITS'(r_ovf != OVF_MAX);
        s_arm       = s_cap ? (r_phase != PH_FALL && r_phase != PH_NEXT)
                            : (r_phase == PH_FALL);
        s_req.high   = s_high;
        s_req.period = s_period;
    end

    // output beat valid
    always_comb begin
        if (s_in_acc && !s_eng_start) begin
            n_ovalid = 1'b1;
        end else if (s_eng_fin) begin
            n_ovalid = 1'b1;
        end else if (o_out.ready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    // phase tracking, overflow count, configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_FIRST;
            r_first  <= '0;
            r_hstamp <= '0;
            r_ovf    <= '0;
            r_sat    <= 1'b0;
            r_tick   <= TICK_RATE_RST;
            r_fs     <= FULL_SCALE_RST;
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
            if (s_eng_start) begin
                r_busy <= 1'b1;
            end else if (s_eng_fin) begin
                r_busy <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_TICK_RATE:  r_tick <= i_cfg_wdata;
                    REG_FULL_SCALE: r_fs   <= i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (s_in_acc) begin
                if (!s_cap) begin
                    r_ovf <= s_ovf_inc;
                    if (s_ovf_inc == OVF_MAX) r_sat <= 1'b1;
                end else begin
                    case (r_phase)
                        PH_FALL: begin
                            r_hstamp <= s_stamp;
                            r_phase  <= PH_NEXT;
                        end
                        PH_NEXT: begin
                            r_ovf   <= '0;
                            r_sat   <= 1'b0;
                            r_phase <= PH_FIRST;
                        end
                        default: begin
                            // first rising edge, also the unused phase code
                            r_first <= i_in.capture_count;
                            r_ovf   <= '0;
                            r_sat   <= 1'b0;
                            r_phase <= PH_FALL;
                        end
                    endcase
                end
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (s_in_acc) begin
            r_arm    <= s_arm;
            r_done   <= s_measure;
            r_high   <= s_measure ? s_high : 32'd0;
            r_period <= s_measure ? s_period : 32'd0;
            r_err    <= s_measure && (s_period == 32'd0 || r_sat);
            r_duty   <= '0;
            r_freq   <= '0;
            r_veff   <= '0;
        end else if (s_eng_fin) begin
            r_duty <= s_res.duty;
            r_freq <= s_res.freq;
            r_veff <= s_res.veff;
        end
    end

    // shared divide and square root engine
    pcm_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (s_eng_start),
        .i_req        (s_req),
        .i_tick_rate  (r_tick),
        .i_full_scale (r_fs),
        .o_busy       (s_eng_busy),
        .o_res        (s_res)
    );

    assign o_out.valid        = r_ovalid;
    assign o_out.arm_falling  = r_arm;
    assign o_out.done_res     = r_done;
    assign o_out.high_ticks   = r_high;
    assign o_out.period_ticks = r_period;
    assign o_out.duty_percent = r_duty;
    assign o_out.frequency_hz = r_freq;
    assign o_out.veff_volts   = r_veff;
    assign o_out.error        = r_err;

    // checks
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_eng_start |-> !r_busy && !s_eng_busy)
        else $error("engine started while a measurement is in progress");

    a_busy_no_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_ovalid)
        else $error("result beat pending while engine runs");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !o_out.ready |=> r_ovalid && $stable(r_high) && $stable(r_duty))
        else $error("stalled result beat changed");

    a_zero_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_done && r_period == 32'd0 |-> r_err)
        else $error("zero period without error flag");

endmodule
